// ===== rtl/core/lfu_pkg.sv =====
// Shared types and constants for the LFU cache lookup block.
// Used by lfu_cmp, lfu_cache_lookup and the testbench; depends on nothing else.
package lfu_pkg;

   localparam int CAPACITY = 16;
   localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CAP_W    = 5;
   localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int KEY_W    = 32;
   localparam int DATA_W   = 32;
   localparam int USE_W    = 32;
   localparam int STAMP_W  = 48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [DATA_W-1:0]  data;
      logic [USE_W-1:0]   use_count;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic key_match;
      logic better;
   } cmp_result_type;

endpackage

// ===== rtl/core/lfu_cmp.sv =====
// Shared compare unit: key match and victim ordering for one table entry.
// Depends on lfu_pkg for the entry and result types.
module lfu_cmp (
   input  logic                            entry_valid,
   input  lfu_pkg::entry_type              entry,
   input  logic [lfu_pkg::KEY_W-1:0]       req_key,
   input  logic                            best_found,
   input  logic [lfu_pkg::USE_W-1:0]       best_count,
   input  logic [lfu_pkg::STAMP_W-1:0]     best_stamp,
   output lfu_pkg::cmp_result_type         res
);

   logic count_lt;
   logic count_eq;
   logic stamp_lt;

   assign count_lt = entry.use_count < best_count;
   assign count_eq = entry.use_count == best_count;
   assign stamp_lt = entry.stamp < best_stamp;

   // Lower count wins; an equal count falls back to the older stamp.
   // A full tie keeps the earlier slot, since the scan runs upward.
   assign res.key_match = entry_valid && (entry.key == req_key);
   assign res.better    = entry_valid &&
                          (!best_found || count_lt || (count_eq && stamp_lt));

endmodule

// ===== rtl/core/lfu_cache_lookup.sv =====
// Top level of the LFU cache lookup: sequencer, entry RAM and valid bits.
// Depends on lfu_pkg and on the shared compare unit lfu_cmp.
//
//  Channel  Dir  Ports                                        Transfer when
//  req      in   req_opcode, req_key, req_write_value         req_valid & req_ready
//  rsp      out  rsp_hit, rsp_read_value                      rsp_valid & rsp_ready
//  csr      in   csr_capacity                                 csr_valid & csr_ready
//
// A request is taken in the idle state, then one scan pass runs over the entry
// RAM through its single registered read port, and a write-back state writes
// back and loads the result register.
// Reset clears the valid bits, the stamp counter and the sequencer and sets
// capacity to 16; the entry RAM is not cleared.
// The write-back cycle waits while the result register still holds an
// untaken result. csr_ready is always high.
module lfu_cache_lookup (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_opcode,
   input  logic [31:0]                 req_key,
   input  logic signed [31:0]          req_write_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_hit,
   output logic signed [31:0]          rsp_read_value,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [4:0]                  csr_capacity
);

   localparam int SLOT_W  = lfu_pkg::SLOT_W;
   localparam int CNT_W   = lfu_pkg::CNT_W;
   localparam int CMP_W   = lfu_pkg::CMP_W;
   localparam int USE_W   = lfu_pkg::USE_W;
   localparam int STAMP_W = lfu_pkg::STAMP_W;
   localparam int Depth   = lfu_pkg::CAPACITY;

   lfu_pkg::state_type          state_ff, state_in;
   logic [lfu_pkg::CAP_W-1:0]   cap_ff, cap_in;
   logic                        op_ff, op_in;
   logic [31:0]                 key_ff, key_in;
   logic [31:0]                 wval_ff, wval_in;
   logic [CNT_W-1:0]            idx_ff, idx_in;
   logic                        cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0]           cmp_slot_ff, cmp_slot_in;
   logic [Depth-1:0]            valid_ff, valid_in;
   logic [STAMP_W-1:0]          stamp_ff, stamp_in;
   logic                        match_found_ff, match_found_in;
   logic [SLOT_W-1:0]           match_slot_ff, match_slot_in;
   lfu_pkg::entry_type          match_entry_ff, match_entry_in;
   logic                        vic_found_ff, vic_found_in;
   logic [SLOT_W-1:0]           vic_slot_ff, vic_slot_in;
   logic [USE_W-1:0]            vic_count_ff, vic_count_in;
   logic [STAMP_W-1:0]          vic_stamp_ff, vic_stamp_in;
   logic                        free_found_ff, free_found_in;
   logic [SLOT_W-1:0]           free_slot_ff, free_slot_in;
   logic [CNT_W-1:0]            used_ff, used_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_hit_ff, rsp_hit_in;
   logic [31:0]                 rsp_value_ff, rsp_value_in;

   lfu_pkg::entry_type          entry_mem [Depth];
   lfu_pkg::entry_type          rd_data_ff;
   logic                        mem_we;
   logic [SLOT_W-1:0]           mem_waddr;
   lfu_pkg::entry_type          mem_wdata;

   lfu_pkg::cmp_result_type     cmp_res;
   logic [CMP_W-1:0]            cap_ext;
   logic [CMP_W-1:0]            eff_cap;
   logic                        table_full;
   logic                        wr_go;
   logic                        insert_go;
   logic [SLOT_W-1:0]           ins_slot;

   localparam logic [lfu_pkg::CAP_W-1:0] CapReset = lfu_pkg::CAP_W'(16);

   lfu_cmp u_cmp (
      .entry_valid (valid_ff[cmp_slot_ff]),
      .entry       (rd_data_ff),
      .req_key     (key_ff),
      .best_found  (vic_found_ff),
      .best_count  (vic_count_ff),
      .best_stamp  (vic_stamp_ff),
      .res         (cmp_res)
   );

   // Zero counts as one entry; anything above the table size saturates.
   assign cap_ext = CMP_W'(cap_ff);
   assign eff_cap = (cap_ext == '0) ? CMP_W'(1) :
                    (cap_ext > CMP_W'(Depth)) ? CMP_W'(Depth) : cap_ext;
   assign table_full = CMP_W'(used_ff) >= eff_cap;

   // After an eviction the lowest free slot is either the victim or an
   // earlier hole left by a lowered capacity.
   assign ins_slot = !table_full ? free_slot_ff :
                     (free_found_ff && (free_slot_ff < vic_slot_ff)) ? free_slot_ff :
                     vic_slot_ff;

   assign wr_go     = (state_ff == lfu_pkg::ST_WRITE) && (!rsp_valid_ff || rsp_ready);
   assign insert_go = wr_go && op_ff && !match_found_ff;

   assign req_ready      = (state_ff == lfu_pkg::ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

   always_comb begin
      state_in       = state_ff;
      cap_in         = csr_valid ? csr_capacity : cap_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      wval_in        = wval_ff;
      idx_in         = idx_ff;
      cmp_vld_in     = cmp_vld_ff;
      cmp_slot_in    = cmp_slot_ff;
      valid_in       = valid_ff;
      stamp_in       = stamp_ff;
      match_found_in = match_found_ff;
      match_slot_in  = match_slot_ff;
      match_entry_in = match_entry_ff;
      vic_found_in   = vic_found_ff;
      vic_slot_in    = vic_slot_ff;
      vic_count_in   = vic_count_ff;
      vic_stamp_in   = vic_stamp_ff;
      free_found_in  = free_found_ff;
      free_slot_in   = free_slot_ff;
      used_in        = used_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_value_in   = rsp_value_ff;
      mem_we         = 1'b0;
      mem_waddr      = match_slot_ff;
      mem_wdata      = match_entry_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         lfu_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in          = req_opcode;
               key_in         = req_key;
               wval_in        = req_write_value;
               idx_in         = '0;
               cmp_vld_in     = 1'b0;
               match_found_in = 1'b0;
               vic_found_in   = 1'b0;
               free_found_in  = 1'b0;
               used_in        = '0;
               state_in       = lfu_pkg::ST_SCAN;
            end
         end

         lfu_pkg::ST_SCAN: begin
            // Issue one RAM read per cycle; its data is compared in the next cycle.
            if (idx_ff != CNT_W'(Depth)) begin
               cmp_vld_in  = 1'b1;
               cmp_slot_in = idx_ff[SLOT_W-1:0];
               idx_in      = idx_ff + CNT_W'(1);
            end else begin
               cmp_vld_in = 1'b0;
               state_in   = lfu_pkg::ST_WRITE;
            end
            if (cmp_vld_ff) begin
               if (valid_ff[cmp_slot_ff]) begin
                  used_in = used_ff + CNT_W'(1);
               end else if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = cmp_slot_ff;
               end
               if (cmp_res.key_match && !match_found_ff) begin
                  match_found_in = 1'b1;
                  match_slot_in  = cmp_slot_ff;
                  match_entry_in = rd_data_ff;
               end
               if (cmp_res.better) begin
                  vic_found_in = 1'b1;
                  vic_slot_in  = cmp_slot_ff;
                  vic_count_in = rd_data_ff.use_count;
                  vic_stamp_in = rd_data_ff.stamp;
               end
            end
         end

         lfu_pkg::ST_WRITE: begin
            if (wr_go) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               rsp_value_in = '1;
               state_in     = lfu_pkg::ST_IDLE;
               if (!op_ff) begin
                  if (match_found_ff) begin
                     rsp_hit_in          = 1'b1;
                     rsp_value_in        = match_entry_ff.data;
                     mem_we              = 1'b1;
                     mem_waddr           = match_slot_ff;
                     mem_wdata           = match_entry_ff;
                     mem_wdata.use_count = (&match_entry_ff.use_count) ?
                                           match_entry_ff.use_count :
                                           match_entry_ff.use_count + USE_W'(1);
                     mem_wdata.stamp     = stamp_ff;
                     stamp_in            = stamp_ff + STAMP_W'(1);
                  end
               end else if (match_found_ff) begin
                  mem_we         = 1'b1;
                  mem_waddr      = match_slot_ff;
                  mem_wdata      = match_entry_ff;
                  mem_wdata.data = wval_ff;
               end else begin
                  if (table_full) begin
                     valid_in[vic_slot_ff] = 1'b0;
                  end
                  valid_in[ins_slot]  = 1'b1;
                  mem_we              = 1'b1;
                  mem_waddr           = ins_slot;
                  mem_wdata.key       = key_ff;
                  mem_wdata.data      = wval_ff;
                  mem_wdata.use_count = '0;
                  mem_wdata.stamp     = stamp_ff;
                  stamp_in            = stamp_ff + STAMP_W'(1);
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfu_pkg::ST_IDLE;
         cap_ff       <= CapReset;
         valid_ff     <= '0;
         stamp_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         valid_ff     <= valid_in;
         stamp_ff     <= stamp_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      wval_ff        <= wval_in;
      idx_ff         <= idx_in;
      cmp_slot_ff    <= cmp_slot_in;
      match_found_ff <= match_found_in;
      match_slot_ff  <= match_slot_in;
      match_entry_ff <= match_entry_in;
      vic_found_ff   <= vic_found_in;
      vic_slot_ff    <= vic_slot_in;
      vic_count_ff   <= vic_count_in;
      vic_stamp_ff   <= vic_stamp_in;
      free_found_ff  <= free_found_in;
      free_slot_ff   <= free_slot_in;
      used_ff        <= used_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_value_ff   <= rsp_value_in;
   end

   // Entry RAM: one write port, one registered read port driven by the scan.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[idx_ff[SLOT_W-1:0]];
   end

   a_scan_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == lfu_pkg::ST_WRITE |-> idx_ff == CNT_W'(Depth))
      else $error("write-back entered before the scan finished");

   a_used_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == lfu_pkg::ST_WRITE |-> used_ff == CNT_W'($countones(valid_ff)))
      else $error("scanned entry count disagrees with the valid bits");

   a_put_no_hit: assert property (@(posedge clock) disable iff (reset)
      wr_go && op_ff |=> rsp_valid_ff && !rsp_hit_ff)
      else $error("put produced a hit result");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      insert_go && !table_full |=>
         $countones(valid_ff) == $countones($past(valid_ff)) + 1)
      else $error("insert without eviction did not add one entry");

   a_insert_evicts: assert property (@(posedge clock) disable iff (reset)
      insert_go && table_full |=>
         $countones(valid_ff) == $countones($past(valid_ff)))
      else $error("insert with eviction changed the entry count");

endmodule

// ===== test/lfu_cache_lookup_tb.sv =====
// Self-checking testbench for lfu_cache_lookup: directed and random get/put traffic
// with capacity changes, checked against an in-bench model of the LFU table.
// Depends on lfu_pkg for the table size and on the lfu_cache_lookup RTL.
module lfu_cache_lookup_tb;

   localparam int SLOTS        = lfu_pkg::CAPACITY;
   localparam bit OP_GET       = 1'b0;
   localparam bit OP_PUT       = 1'b1;
   localparam int DRAIN_CYCLES = 3 * (SLOTS + 3);
   localparam int HOLD_CYCLES  = 400;
   localparam int POOL_MAX     = 32;

   typedef struct {
      bit                 hit;
      logic signed [31:0] value;
   } lookup_reply_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_opcode = OP_GET;
   logic [31:0]        req_key = '0;
   logic signed [31:0] req_write_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_hit;
   logic signed [31:0] rsp_read_value;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [4:0]         csr_capacity = 5'd16;

   // Model of the cache table.
   bit          slot_valid [SLOTS];
   logic [31:0] slot_key   [SLOTS];
   logic [31:0] slot_data  [SLOTS];
   logic [31:0] slot_uses  [SLOTS];
   logic [47:0] slot_stamp [SLOTS];
   logic [47:0] stamp_next  = '0;
   logic [4:0]  cap_setting = 5'd16;

   lookup_reply_type replies_due [$];
   bit [31:0]        key_pool [POOL_MAX];
   int               fail_count  = 0;
   int               reply_count = 0;
   int               stall_left  = 0;
   bit               quiet_mode  = 1'b0;
   bit               hold_active = 1'b0;
   event             hold_start;

   lfu_cache_lookup dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_key         (req_key),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_capacity    (csr_capacity)
   );

   always #1 clock = ~clock;

   initial begin
      #3000000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Applies one request to the table model and queues the reply it must produce.
   task automatic predict_lookup(input bit op, input logic [31:0] k, input logic [31:0] v);
      lookup_reply_type r;
      int i, found, victim, used, room;
      r.hit   = 1'b0;
      r.value = '1;
      found   = -1;
      for (i = 0; i < SLOTS; i++)
         if (found < 0 && slot_valid[i] && slot_key[i] == k) found = i;
      if (op == OP_GET) begin
         if (found >= 0) begin
            if (slot_uses[found] != 32'hFFFF_FFFF) slot_uses[found]++;
            slot_stamp[found] = stamp_next;
            stamp_next++;
            r.hit   = 1'b1;
            r.value = slot_data[found];
         end
      end else if (found >= 0) begin
         slot_data[found] = v;
      end else begin
         used = 0;
         for (i = 0; i < SLOTS; i++)
            if (slot_valid[i]) used++;
         room = (cap_setting == 0) ? 1 : (cap_setting > SLOTS) ? SLOTS : int'(cap_setting);
         if (used >= room) begin
            // Lowest use count loses; equal counts fall to the older stamp, then lower slot.
            victim = -1;
            for (i = 0; i < SLOTS; i++) begin
               if (slot_valid[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                   (slot_uses[i] == slot_uses[victim] && slot_stamp[i] < slot_stamp[victim])))
                  victim = i;
            end
            if (victim >= 0) slot_valid[victim] = 1'b0;
         end
         found = -1;
         for (i = 0; i < SLOTS; i++)
            if (found < 0 && !slot_valid[i]) found = i;
         if (found >= 0) begin
            slot_valid[found] = 1'b1;
            slot_key[found]   = k;
            slot_data[found]  = v;
            slot_uses[found]  = '0;
            slot_stamp[found] = stamp_next;
            stamp_next++;
         end
      end
      replies_due.push_back(r);
   endtask

   // Called at a rising edge; returns at the edge where the request transfer happens.
   task automatic issue_request(input bit op, input logic [31:0] k, input logic [31:0] v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_key         <= k;
      req_write_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_lookup(op, k, v);
   endtask

   // Only written with the block idle: all replies in and a drain period passed.
   task automatic write_capacity(input logic [4:0] cap);
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid    <= 1'b1;
      csr_capacity <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      cap_setting  = cap;
   endtask

   task automatic send_pool_item(input int pool_size);
      logic [31:0] k;
      int r;
      r = $urandom_range(0, 99);
      if (r < 86) k = key_pool[$urandom_range(0, pool_size - 1)];
      else if (r < 96) k = $urandom;
      else if (r < 98) k = 32'h0000_0000;
      else k = 32'hFFFF_FFFF;
      issue_request(1'($urandom_range(0, 1)), k, $urandom);
   endtask

   task automatic run_traffic_phase(input logic [4:0] cap, input int count);
      int i, pool_size;
      write_capacity(cap);
      pool_size = $urandom_range(2, POOL_MAX - 4);
      for (i = 0; i < pool_size; i++) key_pool[i] = $urandom;
      for (i = 0; i < count; i++) send_pool_item(pool_size);
   endtask

   task automatic test_lookup_basics();
      issue_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
      issue_request(OP_PUT, 32'h0000_0000, 32'h8000_0000);
      issue_request(OP_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      issue_request(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // An update stores -1, so the next hit must still report hit set.
      issue_request(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      issue_request(OP_GET, 32'h0000_0000, 32'h1234_5678);
      issue_request(OP_GET, 32'h1234_5678, 32'h55AA_55AA);
   endtask

   task automatic test_replacement_order();
      write_capacity(5'd3);
      issue_request(OP_PUT, 32'h0000_0001, 32'h0000_0011);
      issue_request(OP_PUT, 32'h0000_0002, 32'h0000_0022);
      issue_request(OP_GET, 32'h0000_0001, 32'h0000_0000);
      issue_request(OP_GET, 32'h0000_0002, 32'h0000_0000);
      // All counts are now equal, so the least recently used entry goes.
      issue_request(OP_PUT, 32'h0000_0003, 32'h0000_0033);
      issue_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
   endtask

   task automatic test_capacity_limits();
      // Lowered below the number of valid entries: one eviction per new key only.
      write_capacity(5'd1);
      issue_request(OP_PUT, 32'h0000_0004, 32'h0000_0044);
      issue_request(OP_GET, 32'h0000_0004, 32'h0000_0000);
      write_capacity(5'd0);
      issue_request(OP_PUT, 32'h0000_0005, 32'h0000_0055);
      issue_request(OP_PUT, 32'h0000_0006, 32'h0000_0066);
      issue_request(OP_GET, 32'h0000_0005, 32'h0000_0000);
      write_capacity(5'd31);
      issue_request(OP_PUT, 32'h0000_0007, 32'h0000_0077);
      issue_request(OP_PUT, 32'h0000_0008, 32'h0000_0088);
      issue_request(OP_GET, 32'h0000_0006, 32'h0000_0000);
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(5'd16, 140);
      run_traffic_phase(5'd1, 100);
      run_traffic_phase(5'd5, 140);
      run_traffic_phase(5'd0, 80);
      run_traffic_phase(5'd31, 160);
      run_traffic_phase(5'd2, 100);
      run_traffic_phase(5'd12, 140);
      run_traffic_phase(5'd17, 120);
      run_traffic_phase(5'($urandom_range(0, 31)), 120);
      run_traffic_phase(5'd16, 140);
   endtask

   // The receiver stops for a long stretch while requests keep coming.
   task automatic test_result_backpressure();
      int i;
      quiet_mode = 1'b1;
      run_traffic_phase(5'd8, 0);
      -> hold_start;
      for (i = 0; i < 40; i++) send_pool_item(12);
      quiet_mode = 1'b0;
   endtask

   task automatic test_back_to_back();
      quiet_mode = 1'b1;
      run_traffic_phase(5'($urandom_range(1, 16)), 80);
      quiet_mode = 1'b0;
   endtask

   initial begin
      forever begin
         @(hold_start);
         hold_active <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active <= 1'b0;
      end
   end

   // Reply checker and receiver-side stall pattern.
   always @(posedge clock) begin
      lookup_reply_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            reply_count++;
            if (replies_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("reply %0d arrived with nothing outstanding: hit %0b value %0d",
                           reply_count, rsp_hit, rsp_read_value);
            end else begin
               want = replies_due[0];
               replies_due.delete(0);
               if (rsp_hit !== want.hit || rsp_read_value !== want.value) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("reply %0d mismatch: hit exp %0b got %0b, value exp %0d got %0d",
                              reply_count, want.hit, rsp_hit, want.value, rsp_read_value);
               end
            end
         end
         if (hold_active) begin
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            stall_left = pick_gap();
            rsp_ready <= (stall_left == 0);
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_lookup_basics();
      test_replacement_order();
      test_capacity_limits();
      test_random_traffic();
      test_result_backpressure();
      test_back_to_back();
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
